// ----- sv/conv3x3_rgb_edge_replicate_top_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef CONV3X3_RGB_EDGE_REPLICATE_TOP_DEFINES_SVH
`define CONV3X3_RGB_EDGE_REPLICATE_TOP_DEFINES_SVH

// Property checked on each rising edge, held off while reset is low.
`define C3RE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");

// Property checked on each rising edge, reset included.
`define C3RE_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ----- sv/c3re_pkg.sv -----
// ----------------------------------------------------------------------------
// c3re_pkg
// Shared constants and types of the 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
package c3re_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;

  localparam int unsigned DimW   = 11;
  localparam int unsigned KernW  = 27;
  localparam int unsigned CoefW  = 9;
  localparam int unsigned PixW   = 24;
  localparam int unsigned ProdW  = 18;
  localparam int unsigned SumW   = 22;
  localparam int unsigned CfgIdxW = 3;

  // Register indexes of the write port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MID    = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_idx_e;

  // Kernel (1 2 1; 2 4 2; 1 2 1)/16
  localparam logic [KernW-1:0] KernOuterRst = 27'd263169;
  localparam logic [KernW-1:0] KernMidRst   = 27'd526338;

  localparam logic [DimW-1:0] DimRst = 11'd1024;

  typedef logic [PixW-1:0] pix_t;
  typedef pix_t [2:0]      col_t;   // rows top..bottom

endpackage

// ----- sv/conv3x3_rgb_edge_replicate_top.sv -----
// ----------------------------------------------------------------------------
// conv3x3_rgb_edge_replicate_top
// Streaming 3x3 convolution of RGB pixels with edge replication.
// ----------------------------------------------------------------------------
// Takes one word per clock (pixel or drain) while in_stall_o is low and
// gives a filtered pixel one row plus one pixel behind the input, via the
// line-memory, window, product and output registers. The first drain word
// of a one-row frame steps two column positions and holds the input while
// it does. The rate is set by the line memory: one read and one write of a
// 48-bit row pair per cycle, with a forwarding register for back-to-back
// hits on the same column. Output rounds half up, saturates to 0..255 and
// flags the last pixel of a frame with frame_end_o. A full output register
// under stall holds the whole pipeline and the input with it.
module conv3x3_rgb_edge_replicate_top
  import c3re_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [KernW-1:0] cfg_data_i,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             op_i,
  input  logic [7:0]       pixel_red_i,
  input  logic [7:0]       pixel_green_i,
  input  logic [7:0]       pixel_blue_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_blue_o,
  output logic             frame_end_o
);

  localparam int unsigned AW  = $clog2(MAX_WIDTH);
  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HCW = $clog2(MAX_HEIGHT + 2);

  // configuration registers
  logic [DimW-1:0]  fw_q, fh_q;
  logic [KernW-1:0] k_top_q, k_mid_q, k_bot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= DimRst;
      fh_q    <= DimRst;
      k_top_q <= KernOuterRst;
      k_mid_q <= KernMidRst;
      k_bot_q <= KernOuterRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:   fw_q    <= cfg_data_i[DimW-1:0];
        CFG_FRAME_HEIGHT:  fh_q    <= cfg_data_i[DimW-1:0];
        CFG_KERNEL_TOP:    k_top_q <= cfg_data_i;
        CFG_KERNEL_MID:    k_mid_q <= cfg_data_i;
        CFG_KERNEL_BOTTOM: k_bot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic dim_wr;
  assign dim_wr = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_FRAME_WIDTH ||
                               cfg_idx_e'(cfg_idx_i) == CFG_FRAME_HEIGHT);

  // clamp frame size into 1..MAX
  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;
  always_comb begin
    if (fw_q == '0)                          w_eff = WCW'(1);
    else if (32'(fw_q) > 32'(MAX_WIDTH))     w_eff = WCW'(MAX_WIDTH);
    else                                     w_eff = WCW'(fw_q);
    if (fh_q == '0)                          h_eff = HCW'(1);
    else if (32'(fh_q) > 32'(MAX_HEIGHT))    h_eff = HCW'(MAX_HEIGHT);
    else                                     h_eff = HCW'(fh_q);
  end

  // pipeline advance: hold everything while a result waits under stall
  logic out_valid_q, adv, sec_q, in_acc;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv || sec_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // position bookkeeping
  // ---------------------------------------------------------------------------
  logic [WCW-1:0] ic_q, oc_q;
  logic [HCW-1:0] ir_q, orow_q;
  logic [WCW-1:0] ic_d, oc_d;
  logic [HCW-1:0] ir_d, orow_d;
  logic           go, dbl, v_pix, v_col0, v_emit, v_lc, v_rc, v_tr, v_br, v_fe;
  logic [AW-1:0]  v_addr;

  always_comb begin
    ic_d   = ic_q;
    ir_d   = ir_q;
    oc_d   = oc_q;
    orow_d = orow_q;
    go     = 1'b0;
    dbl    = 1'b0;
    v_pix  = 1'b0;
    if (sec_q) begin
      go = 1'b1;
    end else if (in_acc) begin
      if (ic_d >= w_eff || ir_d > h_eff + HCW'(1)) begin
        ic_d = '0; ir_d = '0; oc_d = '0; orow_d = '0;
      end
      if (!op_i) begin
        v_pix = 1'b1;
        go    = 1'b1;
        if (ir_d >= h_eff) begin
          ic_d = '0; ir_d = '0; oc_d = '0; orow_d = '0;
        end
      end else if (ir_d >= h_eff) begin
        go = 1'b1;
      end
    end
    v_addr = ic_d[AW-1:0];
    v_col0 = (ic_d == '0);
    v_emit = v_col0 ? (ir_d >= HCW'(2)) : (ir_d >= HCW'(1));
    v_lc   = (oc_d == '0);
    v_rc   = (oc_d + WCW'(1) >= w_eff);
    v_tr   = (orow_d == '0);
    v_br   = (orow_d + HCW'(1) >= h_eff);
    v_fe   = v_emit && v_rc && v_br;
    if (go) begin
      if (v_fe) begin
        ic_d = '0; ir_d = '0; oc_d = '0; orow_d = '0;
      end else begin
        if (v_emit) begin
          if (oc_d + WCW'(1) >= w_eff) begin
            oc_d   = '0;
            orow_d = orow_d + HCW'(1);
          end else begin
            oc_d = oc_d + WCW'(1);
          end
        end
        if (ic_d + WCW'(1) >= w_eff) begin
          ic_d = '0;
          ir_d = ir_d + HCW'(1);
        end else begin
          ic_d = ic_d + WCW'(1);
        end
      end
      dbl = !sec_q && !v_pix && !v_emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= '0; ir_q <= '0; oc_q <= '0; orow_q <= '0;
      sec_q <= 1'b0;
    end else if (dim_wr) begin
      ic_q <= '0; ir_q <= '0; oc_q <= '0; orow_q <= '0;
    end else if (adv) begin
      ic_q   <= ic_d;
      ir_q   <= ir_d;
      oc_q   <= oc_d;
      orow_q <= orow_d;
      sec_q  <= dbl;
    end
  end

  // ---------------------------------------------------------------------------
  // line memory stage: {upper, lower} per column
  // ---------------------------------------------------------------------------
  logic [2*PixW-1:0] line_mem [MAX_WIDTH];
  logic [2*PixW-1:0] rdata_q, fwd_q;
  logic              b_valid_q, b_pix_q, b_col0_q, b_emit_q, b_fwd_q;
  logic              b_lc_q, b_rc_q, b_tr_q, b_br_q, b_fe_q;
  logic [AW-1:0]     b_addr_q;
  pix_t              b_px_q;
  pix_t              u_eff, l_eff;

  assign {u_eff, l_eff} = b_fwd_q ? fwd_q : rdata_q;

  // read ahead, write back, and keep the last write for a repeated column
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (go) begin
        rdata_q <= line_mem[v_addr];
      end
      if (b_valid_q && b_pix_q) begin
        line_mem[b_addr_q] <= {l_eff, b_px_q};
        fwd_q              <= {l_eff, b_px_q};
      end
      b_addr_q <= v_addr;
      b_px_q   <= {pixel_blue_i, pixel_green_i, pixel_red_i};
      b_pix_q  <= v_pix;
      b_col0_q <= v_col0;
      b_emit_q <= v_emit;
      b_lc_q   <= v_lc;
      b_rc_q   <= v_rc;
      b_tr_q   <= v_tr;
      b_br_q   <= v_br;
      b_fe_q   <= v_fe;
      b_fwd_q  <= b_valid_q && b_pix_q && (b_addr_q == v_addr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= go;
    end
  end

  // ---------------------------------------------------------------------------
  // window and edge replication
  // ---------------------------------------------------------------------------
  col_t [2:0] win_q;
  col_t       new_col, cl, cc, cr;
  pix_t       g [3][3];
  pix_t       g_q [3][3];
  logic       c_valid_q, c_fe_q;

  always_comb begin
    new_col[0] = u_eff;
    new_col[1] = l_eff;
    new_col[2] = b_pix_q ? b_px_q : l_eff;
    cl = win_q[1];
    cc = win_q[2];
    cr = b_col0_q ? win_q[2] : new_col;
    for (int r = 0; r < 3; r++) begin
      g[r][0] = b_lc_q ? cc[r] : cl[r];
      g[r][1] = cc[r];
      g[r][2] = b_rc_q ? cc[r] : cr[r];
    end
    for (int c = 0; c < 3; c++) begin
      if (b_tr_q) g[0][c] = g[1][c];
      if (b_br_q) g[2][c] = g[1][c];
    end
  end

  // shift the window one column on every visit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      c_valid_q <= 1'b0;
    end else if (adv) begin
      if (b_valid_q) begin
        win_q <= {new_col, win_q[2], win_q[1]};
      end
      c_valid_q <= b_valid_q && b_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_q    <= g;
      c_fe_q <= b_fe_q;
    end
  end

  // ---------------------------------------------------------------------------
  // products: nine per channel
  // ---------------------------------------------------------------------------
  logic [KernW-1:0]         krow [3];
  logic signed [ProdW-1:0]  prod_q [3][3][3];   // [channel][row][column]
  logic                     p_valid_q, p_fe_q;

  assign krow[0] = k_top_q;
  assign krow[1] = k_mid_q;
  assign krow[2] = k_bot_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            prod_q[ch][r][c] <= ProdW'($signed(krow[r][CoefW*c +: CoefW]) *
                                       $signed({1'b0, g_q[r][c][8*ch +: 8]}));
          end
        end
      end
      p_fe_q <= c_fe_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (adv) begin
      p_valid_q <= c_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // sum, round half up, saturate
  // ---------------------------------------------------------------------------
  logic signed [SumW-1:0] sum [3];
  logic [7:0]             res [3];
  logic [7:0]             res_q [3];
  logic                   fe_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = SumW'(8);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          sum[ch] = sum[ch] + SumW'(prod_q[ch][r][c]);
        end
      end
      if (sum[ch] < 0)                    res[ch] = 8'd0;
      else if ((sum[ch] >>> 4) > 255)     res[ch] = 8'd255;
      else                                res[ch] = sum[ch][11:4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
      fe_q  <= p_fe_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = res_q[0];
  assign out_green_o = res_q[1];
  assign out_blue_o  = res_q[2];
  assign frame_end_o = fe_q;

endmodule

// ----- sv/c3re_checker.sv -----
// ----------------------------------------------------------------------------
// c3re_checker
// Port-level checks of the 3x3 convolution block, bound to its top level.
// ----------------------------------------------------------------------------
`include "conv3x3_rgb_edge_replicate_top_defines.svh"

module c3re_checker
  import c3re_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_red_o,
  input logic [7:0] out_green_o,
  input logic [7:0] out_blue_o,
  input logic       frame_end_o
);

  // a blocked word holds its place and value
  `C3RE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o) && $stable(frame_end_o))

  // nothing is taken in while the output is blocked
  `C3RE_ASSERT(a_in_blocked, clk_i, rst_ni, out_valid_o && out_stall_i |-> in_stall_o)

  // the pipeline leaves reset empty
  `C3RE_ASSERT_RST(a_rst_empty, clk_i, !$past(rst_ni) |-> !out_valid_o)

endmodule

bind conv3x3_rgb_edge_replicate_top c3re_checker u_c3re_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_red_o   (out_red_o),
  .out_green_o (out_green_o),
  .out_blue_o  (out_blue_o),
  .frame_end_o (frame_end_o)
);
